/* design/fcs_pkg.sv */
// Shared types and constants for the Fenwick max chain score unit.
`default_nettype none

package fcs_pkg;

    localparam int SCORE_W = 20;
    localparam int AGE_W   = 10;
    localparam int OUT_W   = 40;
    localparam int TAG_BITS = 8;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_SWEEP_SET,
        ST_IDLE,
        ST_Q_START,
        ST_Q_CMP,
        ST_ADD,
        ST_U_CMP,
        ST_OUT
    } fcs_state_t;

endpackage

`default_nettype wire

/* design/fenwick_max_chain_score_unit.sv */
// Top level of the Fenwick max chain score unit: sequencer, tree memory and output register.
`default_nettype none

// Each accepted word (score, age) is scored against a Fenwick tree of prefix maxima held in one
// RAM whose single read port is used once per cycle. A word is handled in steps: a query walk
// that reads one tree node per set bit of age, an add, an update walk over the tree nodes on
// the update path from age (at most log2(KEY_SLOTS) of them), and the output step; an age of
// zero skips both tree walks. A first-of-set word normally clears the tree at once by advancing
// an epoch tag stored with each entry; every 255th set, and once after reset, a clearing pass
// writes all KEY_SLOTS entries, one per cycle, during which no word is accepted. The result
// waits in an output register, so the next word is taken while it is still pending.
module fenwick_max_chain_score_unit
    import fcs_pkg::*;
#(
    parameter int KEY_SLOTS = 1024,
    parameter int SUM_BITS  = 40
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // player_score[19:0], player_age[29:20], zeros above
    input  wire logic        s_tuser,   // first_of_set
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [79:0] m_tdata    // best_ending_here[39:0], best_overall[79:40]
);

    localparam int AW = $clog2(KEY_SLOTS);
    localparam int KW = AW + 1;
    localparam int EW = SUM_BITS + TAG_BITS;

    fcs_state_t state_reg, state_next;
    logic [TAG_BITS-1:0] epoch_reg, epoch_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [KW-1:0]       key_reg, key_next;
    logic [SCORE_W-1:0]  score_reg, score_next;
    logic [SUM_BITS-1:0] best_reg, best_next;
    logic [SUM_BITS-1:0] here_reg, here_next;
    logic [SUM_BITS-1:0] run_reg, run_next;
    logic [AW-1:0]       sweep_reg, sweep_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]    m_here_reg, m_here_next;
    logic [OUT_W-1:0]    m_over_reg, m_over_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [EW-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [EW-1:0]       ram_rdata;

    logic [SUM_BITS-1:0] cur_val;
    logic [KW-1:0]       key_clamp;
    logic [KW-1:0]       k_down;
    logic [KW-1:0]       k_up;
    logic [SUM_BITS:0]   sum_full;
    logic [SUM_BITS-1:0] sum_sat;
    logic [63:0]         here_wide;
    logic [63:0]         run_wide;

    fcs_ram #(
        .WIDTH(EW),
        .DEPTH(KEY_SLOTS)
    ) u_tree (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // An entry written under an older epoch reads as empty.
    assign cur_val = (ram_rdata[SUM_BITS +: TAG_BITS] == epoch_reg) ?
                     ram_rdata[SUM_BITS-1:0] : '0;

    assign key_clamp = (32'(s_tdata[29:20]) >= 32'(KEY_SLOTS)) ? KW'(KEY_SLOTS - 1)
                                                               : KW'(s_tdata[29:20]);
    assign k_down = k_reg & (k_reg - KW'(1));
    assign k_up   = k_reg + (k_reg & (~k_reg + KW'(1)));

    assign sum_full = {1'b0, best_reg} + (SUM_BITS + 1)'(score_reg);
    assign sum_sat  = sum_full[SUM_BITS] ? '1 : sum_full[SUM_BITS-1:0];

    assign here_wide = 64'(here_reg);
    assign run_wide  = 64'(run_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SWEEP;
            epoch_reg    <= '0;
            sweep_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            run_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            epoch_reg    <= epoch_next;
            sweep_reg    <= sweep_next;
            m_tvalid_reg <= m_tvalid_next;
            run_reg      <= run_next;
        end
        k_reg      <= k_next;
        key_reg    <= key_next;
        score_reg  <= score_next;
        best_reg   <= best_next;
        here_reg   <= here_next;
        m_here_reg <= m_here_next;
        m_over_reg <= m_over_next;
    end

    always_comb begin
        state_next    = state_reg;
        epoch_next    = epoch_reg;
        k_next        = k_reg;
        key_next      = key_reg;
        score_next    = score_reg;
        best_next     = best_reg;
        here_next     = here_reg;
        run_next      = run_reg;
        sweep_next    = sweep_reg;
        m_tvalid_next = m_tvalid_reg;
        m_here_next   = m_here_reg;
        m_over_next   = m_over_reg;
        ram_we        = 1'b0;
        ram_waddr     = k_reg[AW-1:0];
        ram_wdata     = {epoch_reg, here_reg};
        ram_raddr     = k_reg[AW-1:0];

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_SWEEP, ST_SWEEP_SET: begin
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = '0;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(KEY_SLOTS - 1)) begin
                    sweep_next = '0;
                    epoch_next = TAG_BITS'(1);
                    state_next = (state_reg == ST_SWEEP) ? ST_IDLE : ST_Q_START;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    score_next = s_tdata[19:0];
                    key_next   = key_clamp;
                    if (s_tuser) begin
                        run_next = '0;
                        if (epoch_reg == '1) begin
                            state_next = ST_SWEEP_SET;
                        end else begin
                            epoch_next = epoch_reg + TAG_BITS'(1);
                            state_next = ST_Q_START;
                        end
                    end else begin
                        state_next = ST_Q_START;
                    end
                end
            end
            ST_Q_START: begin
                best_next = '0;
                k_next    = key_reg;
                ram_raddr = key_reg[AW-1:0];
                state_next = (key_reg == '0) ? ST_ADD : ST_Q_CMP;
            end
            ST_Q_CMP: begin
                if (cur_val > best_reg) begin
                    best_next = cur_val;
                end
                k_next    = k_down;
                ram_raddr = k_down[AW-1:0];
                if (k_down == '0) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                here_next = sum_sat;
                if (sum_sat > run_reg) begin
                    run_next = sum_sat;
                end
                k_next    = key_reg;
                ram_raddr = key_reg[AW-1:0];
                state_next = (key_reg == '0) ? ST_OUT : ST_U_CMP;
            end
            ST_U_CMP: begin
                if (cur_val < here_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = k_reg[AW-1:0];
                    ram_wdata = {epoch_reg, here_reg};
                end
                k_next    = k_up;
                ram_raddr = k_up[AW-1:0];
                if (k_up >= KW'(KEY_SLOTS)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_here_next   = here_wide[OUT_W-1:0];
                    m_over_next   = run_wide[OUT_W-1:0];
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_over_reg, m_here_reg};

endmodule

`default_nettype wire

/* design/fcs_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module fcs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* bench/tb_fenwick_max_chain_score_unit.sv */
// Self-checking testbench for the Fenwick max chain score unit: directed table, then random sets.
`default_nettype none

module tb_fenwick_max_chain_score_unit;
    import fcs_pkg::*;

    localparam int KEY_SLOTS = 1024;
    localparam int SUM_BITS  = 40;
    localparam logic [63:0] SUM_MAX = (64'd1 << SUM_BITS) - 64'd1;
    localparam logic [SCORE_W-1:0] SCORE_TOP = {SCORE_W{1'b1}};
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int CHUNK_WORDS    = 75;

    typedef struct packed {
        logic [OUT_W-1:0] here;
        logic [OUT_W-1:0] overall;
    } chain_result_t;

    typedef struct packed {
        logic               first;
        logic [SCORE_W-1:0] score;
        logic [AGE_W-1:0]   age;
        logic               typed;
        logic [OUT_W-1:0]   here;
        logic [OUT_W-1:0]   overall;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 20;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b0, 20'd5,       10'd3,    1'b1, 40'd5,       40'd5},
        '{1'b1, 20'd1,       10'd1,    1'b1, 40'd1,       40'd1},
        '{1'b0, 20'hFFFFF,   10'd1023, 1'b1, 40'h100000,  40'h100000},
        '{1'b0, 20'd7,       10'd0,    1'b1, 40'd7,       40'h100000},
        '{1'b0, 20'd0,       10'd1023, 1'b1, 40'h100000,  40'h100000},
        '{1'b1, 20'd0,       10'd0,    1'b1, 40'd0,       40'd0},
        '{1'b1, 20'hFFFFF,   10'd1023, 1'b1, 40'hFFFFF,   40'hFFFFF},
        '{1'b0, 20'hFFFFF,   10'd512,  1'b0, 40'd0,       40'd0},
        '{1'b0, 20'hFFFFF,   10'd1,    1'b0, 40'd0,       40'd0},
        '{1'b1, 20'd10,      10'd4,    1'b0, 40'd0,       40'd0},
        '{1'b0, 20'd10,      10'd8,    1'b0, 40'd0,       40'd0},
        '{1'b0, 20'd20,      10'd2,    1'b0, 40'd0,       40'd0},
        '{1'b0, 20'd20,      10'd6,    1'b0, 40'd0,       40'd0},
        '{1'b0, 20'd30,      10'd512,  1'b0, 40'd0,       40'd0},
        '{1'b0, 20'd30,      10'd513,  1'b0, 40'd0,       40'd0},
        '{1'b0, 20'd5,       10'd2,    1'b0, 40'd0,       40'd0},
        '{1'b0, 20'd3,       10'd1023, 1'b0, 40'd0,       40'd0},
        '{1'b1, 20'h55555,   10'h2AA,  1'b0, 40'd0,       40'd0},
        '{1'b0, 20'hAAAAA,   10'h155,  1'b0, 40'd0,       40'd0},
        '{1'b0, 20'd1,       10'd0,    1'b0, 40'd0,       40'd0}
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // player_score[19:0], player_age[29:20], zeros above
    logic        s_tuser  = 1'b0; // first_of_set
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;         // best_ending_here[39:0], best_overall[79:40]

    fenwick_max_chain_score_unit #(
        .KEY_SLOTS(KEY_SLOTS),
        .SUM_BITS (SUM_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    logic [SUM_BITS-1:0] chain_tree [KEY_SLOTS];
    logic [SUM_BITS-1:0] set_best;
    chain_result_t       pending_scores [$];
    int                  mismatch_count = 0;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    int                  words_sent     = 0;
    int                  quiet_cycles   = 0;

    function automatic void clear_chains();
        for (int i = 0; i < KEY_SLOTS; i++) begin
            chain_tree[i] = '0;
        end
        set_best = '0;
    endfunction

    function automatic chain_result_t score_chain(logic first, logic [SCORE_W-1:0] score,
                                                  logic [AGE_W-1:0] age);
        int unsigned   key;
        int unsigned   k;
        logic [63:0]   best;
        logic [63:0]   total;
        chain_result_t res;
        if (first) begin
            clear_chains();
        end
        key = 32'(age);
        if (key >= KEY_SLOTS) begin
            key = KEY_SLOTS - 1;
        end
        k = key;
        best = '0;
        while (k > 0) begin
            if (64'(chain_tree[k]) > best) begin
                best = 64'(chain_tree[k]);
            end
            k = k & (k - 1);
        end
        total = best + 64'(score);
        if (total > SUM_MAX) begin
            total = SUM_MAX;
        end
        k = key;
        if (k != 0) begin
            while (k < KEY_SLOTS) begin
                if (64'(chain_tree[k]) < total) begin
                    chain_tree[k] = total[SUM_BITS-1:0];
                end
                k = k + (k & (~k + 1));
            end
        end
        if (total > 64'(set_best)) begin
            set_best = total[SUM_BITS-1:0];
        end
        res.here    = total[OUT_W-1:0];
        res.overall = OUT_W'(set_best);
        return res;
    endfunction

    task automatic send_word(logic first, logic [SCORE_W-1:0] score, logic [AGE_W-1:0] age,
                             logic typed, logic [OUT_W-1:0] here, logic [OUT_W-1:0] overall);
        chain_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, age, score};
        s_tuser  <= first;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        res = score_chain(first, score, age);
        if (typed) begin
            res.here    = here;
            res.overall = overall;
        end
        pending_scores = {pending_scores, res};
        words_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic send_set();
        logic [SCORE_W-1:0] score;
        logic [AGE_W-1:0]   age;
        int                 len;
        int                 kind;
        kind = $urandom_range(99);
        if (kind < 12) begin
            send_word(1'($urandom_range(1)), SCORE_W'($urandom_range(0, SCORE_TOP)),
                      AGE_W'($urandom_range(0, 1023)), 1'b0, '0, '0);
            return;
        end
        len   = ($urandom_range(19) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        score = SCORE_W'($urandom_range(0, SCORE_TOP));
        age   = ($urandom_range(19) == 0) ? '0 : AGE_W'($urandom_range(0, 1023));
        for (int i = 0; i < len; i++) begin
            send_word((i == 0) && (kind >= 20), score, age, 1'b0, '0, '0);
            if (kind < 20 && $urandom_range(1) == 0) begin
                score = SCORE_W'($urandom_range(0, SCORE_TOP));
                age   = AGE_W'($urandom_range(0, 1023));
            end else if ($urandom_range(3) == 0) begin
                age = AGE_W'($urandom_range(age, 1023));
            end else begin
                score = (int'(score) + 5000 > int'(SCORE_TOP)) ? SCORE_TOP
                        : score + SCORE_W'($urandom_range(1, 5000));
                age   = ($urandom_range(19) == 0) ? '0 : AGE_W'($urandom_range(0, 1023));
            end
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : check_results
        chain_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_scores.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected result word here=%h overall=%h",
                             m_tdata[OUT_W-1:0], m_tdata[2*OUT_W-1:OUT_W]);
                end
                mismatch_count++;
            end else begin
                want = pending_scores.pop_front();
                if (m_tdata[OUT_W-1:0] !== want.here
                        || m_tdata[2*OUT_W-1:OUT_W] !== want.overall) begin
                    if (mismatch_count < 10) begin
                        $display("mismatch: here exp %h got %h, overall exp %h got %h",
                                 want.here, m_tdata[OUT_W-1:0],
                                 want.overall, m_tdata[2*OUT_W-1:OUT_W]);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_fenwick_max_chain_score_unit failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int chunk;
        int chunk_start;
        clear_chains();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_word(DIRECTED[i].first, DIRECTED[i].score, DIRECTED[i].age,
                      DIRECTED[i].typed, DIRECTED[i].here, DIRECTED[i].overall);
        end
        drain_results();

        chunk = 0;
        while (words_sent < 900 + DIRECTED_ROWS) begin
            case (chunk % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 72;
                end
                default: begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            chunk_start = words_sent;
            while (words_sent - chunk_start < CHUNK_WORDS) begin
                send_set();
            end
            drain_results();
            chunk++;
        end

        recv_stall_pct = 0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_scores.size() == 0) begin
            $display("tb_fenwick_max_chain_score_unit passed");
        end else begin
            $display("tb_fenwick_max_chain_score_unit failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
design/fcs_pkg.sv
design/fcs_ram.sv
design/fenwick_max_chain_score_unit.sv
bench/tb_fenwick_max_chain_score_unit.sv
